// ===== rtl/core/ilbm_pkg.sv =====
package ilbm_pkg;

  localparam int unsigned XW = 13;
  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [31:0] TAG_FORM = 32'h464F524D;
  localparam logic [31:0] TAG_ILBM = 32'h494C424D;
  localparam logic [31:0] TAG_BMHD = 32'h424D4844;
  localparam logic [31:0] TAG_BODY = 32'h424F4459;

  localparam int unsigned DEF_WIDTH = 320;
  localparam int unsigned DEF_HEIGHT = 200;
  localparam logic [7:0] DEF_PLANES = 8'd4;
  localparam logic [4:0] BMHD_LEN = 5'd20;
  localparam logic [4:0] HEAD_LEN = 5'd12;
  localparam logic [4:0] FIELD_LEN = 5'd4;
  localparam logic [4:0] OFF_WIDTH_HI = 5'd0;
  localparam logic [4:0] OFF_WIDTH_LO = 5'd1;
  localparam logic [4:0] OFF_HEIGHT_HI = 5'd2;
  localparam logic [4:0] OFF_HEIGHT_LO = 5'd3;
  localparam logic [4:0] OFF_PLANES = 5'd8;
  localparam logic [7:0] PIXEL_ON = 8'd255;
  localparam logic [7:0] PIXEL_OFF = 8'd0;

  localparam logic ST_OK = 1'b0;
  localparam logic ST_NOT_IFF = 1'b1;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_TAG,
    PH_SIZE,
    PH_DATA,
    PH_PAD,
    PH_BODY,
    PH_DONE
  } phase_t;

  typedef enum logic [1:0] {
    RK_INFO   = 2'd0,
    RK_PIXEL  = 2'd1,
    RK_FINISH = 2'd2
  } res_kind_t;

  typedef struct packed {
    res_kind_t       kind;
    logic            fin;
    logic            status;
    logic [7:0]      data;
    logic [XW-1:0]   base_x;
    logic [XW-1:0]   row;
    logic [3:0]      npix;
    logic [XW-1:0]   width;
    logic [XW-1:0]   height;
    logic [7:0]      planes;
  } job_t;

endpackage

// ===== rtl/core/ilbm_front.sv =====
module ilbm_front
  import ilbm_pkg::*;
#(
  parameter int unsigned MAX_WIDTH = 320,
  parameter int unsigned MAX_HEIGHT = 256
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] data_byte,
  input  logic       end_marker,
  output logic       job_push,
  output job_t       job,
  input  logic       queue_full
);

  localparam int unsigned WLIM = (MAX_WIDTH > DEF_WIDTH) ? MAX_WIDTH : DEF_WIDTH;
  localparam int unsigned HLIM = (MAX_HEIGHT > DEF_HEIGHT) ? MAX_HEIGHT : DEF_HEIGHT;
  localparam int unsigned WW = $clog2(WLIM + 1);
  localparam int unsigned HW = $clog2(HLIM + 1);
  localparam int unsigned RBW = $clog2((WLIM + 7) / 8 + 1);
  localparam int unsigned DW = ((WW > RBW + 3) ? WW : RBW + 3) + 1;

  phase_t          phase, phase_next;
  logic [4:0]      fcnt, fcnt_next;
  logic [31:0]     tag, tag_next;
  logic [31:0]     clen, clen_next;
  logic [31:0]     left, left_next;
  logic [WW-1:0]   width, width_next;
  logic [HW-1:0]   height, height_next;
  logic [7:0]      planes, planes_next;
  logic [HW-1:0]   row, row_next;
  logic [RBW-1:0]  rbyte, rbyte_next;
  logic            hvalid, hvalid_next;
  logic [7:0]      msb, msb_next;

  logic            accept;
  logic [31:0]     tag_sh;
  logic [31:0]     len_sh;
  logic [4:0]      cnt_inc;
  logic [31:0]     left_dec;
  logic [15:0]     w16;
  logic [RBW+2:0]  base_x;
  logic [DW-1:0]   diff;
  logic [RBW:0]    rbyte_inc;
  logic [WW:0]     row_bytes;
  logic [HW:0]     row_inc;

  assign in_ready = !queue_full;
  assign accept = in_valid && in_ready;
  assign tag_sh = {tag[23:0], data_byte};
  assign len_sh = {clen[23:0], data_byte};
  assign cnt_inc = fcnt + 5'd1;
  assign left_dec = left - 32'd1;
  assign w16 = {msb, data_byte};
  assign base_x = {rbyte, 3'b000};
  assign diff = DW'(width) - DW'(base_x);
  assign rbyte_inc = (RBW + 1)'(rbyte) + (RBW + 1)'(1);
  assign row_bytes = ((WW + 1)'(width) + (WW + 1)'(7)) >> 3;
  assign row_inc = (HW + 1)'(row) + (HW + 1)'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= PH_HEADER;
      fcnt   <= '0;
      tag    <= '0;
      clen   <= '0;
      left   <= '0;
      width  <= WW'(DEF_WIDTH);
      height <= HW'(DEF_HEIGHT);
      planes <= DEF_PLANES;
      row    <= '0;
      rbyte  <= '0;
      hvalid <= 1'b0;
      msb    <= '0;
    end else begin
      phase  <= phase_next;
      fcnt   <= fcnt_next;
      tag    <= tag_next;
      clen   <= clen_next;
      left   <= left_next;
      width  <= width_next;
      height <= height_next;
      planes <= planes_next;
      row    <= row_next;
      rbyte  <= rbyte_next;
      hvalid <= hvalid_next;
      msb    <= msb_next;
    end
  end

  always_comb begin
    phase_next  = phase;
    fcnt_next   = fcnt;
    tag_next    = tag;
    clen_next   = clen;
    left_next   = left;
    width_next  = width;
    height_next = height;
    planes_next = planes;
    row_next    = row;
    rbyte_next  = rbyte;
    hvalid_next = hvalid;
    msb_next    = msb;
    job_push    = 1'b0;
    job         = '0;
    job.kind    = RK_FINISH;
    if (accept) begin
      if (end_marker) begin
        if (phase == PH_HEADER) begin
          job_push   = 1'b1;
          job.status = ST_NOT_IFF;
        end else if (phase != PH_DONE) begin
          job_push   = 1'b1;
          job.status = hvalid ? ST_OK : ST_NOT_IFF;
        end
        phase_next  = PH_HEADER;
        fcnt_next   = '0;
        tag_next    = '0;
        clen_next   = '0;
        left_next   = '0;
        width_next  = WW'(DEF_WIDTH);
        height_next = HW'(DEF_HEIGHT);
        planes_next = DEF_PLANES;
        row_next    = '0;
        rbyte_next  = '0;
        hvalid_next = 1'b0;
        msb_next    = '0;
      end else begin
        case (phase)
          PH_HEADER: begin
            tag_next  = tag_sh;
            fcnt_next = cnt_inc;
            if (cnt_inc == FIELD_LEN) begin
              hvalid_next = (tag_sh == TAG_FORM);
            end
            if (cnt_inc >= HEAD_LEN) begin
              fcnt_next = '0;
              tag_next  = '0;
              if (hvalid && tag_sh == TAG_ILBM) begin
                phase_next = PH_TAG;
              end else begin
                hvalid_next = 1'b0;
                phase_next  = PH_DONE;
                job_push    = 1'b1;
                job.status  = ST_NOT_IFF;
              end
            end
          end
          PH_TAG: begin
            tag_next  = tag_sh;
            fcnt_next = cnt_inc;
            if (cnt_inc >= FIELD_LEN) begin
              fcnt_next  = '0;
              clen_next  = '0;
              phase_next = PH_SIZE;
            end
          end
          PH_SIZE: begin
            clen_next = len_sh;
            fcnt_next = cnt_inc;
            if (cnt_inc >= FIELD_LEN) begin
              fcnt_next = '0;
              left_next = len_sh;
              if (tag == TAG_BODY) begin
                job_push    = 1'b1;
                job.kind    = RK_INFO;
                job.width   = XW'(width);
                job.height  = XW'(height);
                job.planes  = planes;
                row_next    = '0;
                rbyte_next  = '0;
                if (len_sh == 32'd0 || width == '0 || height == '0) begin
                  job.fin    = 1'b1;
                  phase_next = PH_DONE;
                end else begin
                  phase_next = PH_BODY;
                end
              end else if (len_sh == 32'd0) begin
                tag_next   = '0;
                phase_next = PH_TAG;
              end else begin
                phase_next = PH_DATA;
              end
            end
          end
          PH_DATA: begin
            if (tag == TAG_BMHD && fcnt < BMHD_LEN) begin
              case (fcnt)
                OFF_WIDTH_HI, OFF_HEIGHT_HI: msb_next = data_byte;
                OFF_WIDTH_LO: begin
                  width_next = (32'(w16) > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(w16);
                end
                OFF_HEIGHT_LO: begin
                  height_next = (32'(w16) > MAX_HEIGHT) ? HW'(MAX_HEIGHT) : HW'(w16);
                end
                OFF_PLANES: planes_next = data_byte;
                default: ;
              endcase
              fcnt_next = cnt_inc;
            end
            left_next = left_dec;
            if (left_dec == 32'd0) begin
              fcnt_next  = '0;
              tag_next   = '0;
              phase_next = clen[0] ? PH_PAD : PH_TAG;
            end
          end
          PH_PAD: begin
            phase_next = PH_TAG;
          end
          PH_BODY: begin
            job_push    = 1'b1;
            job.kind    = RK_PIXEL;
            job.data    = data_byte;
            job.base_x  = XW'(base_x);
            job.row     = XW'(row);
            job.npix    = (diff >= DW'(8)) ? 4'd8 : 4'(diff);
            left_next   = left_dec;
            rbyte_next  = RBW'(rbyte_inc);
            row_next    = row;
            if (32'(rbyte_inc) >= 32'(row_bytes)) begin
              rbyte_next = '0;
              row_next   = HW'(row_inc);
            end
            if ((32'(rbyte_inc) >= 32'(row_bytes) && row_inc >= (HW + 1)'(height)) ||
                (32'(rbyte_inc) < 32'(row_bytes) && row >= height) ||
                left_dec == 32'd0) begin
              job.fin    = 1'b1;
              phase_next = PH_DONE;
            end
          end
          PH_DONE: ;
          default: ;
        endcase
      end
    end
  end

endmodule

// ===== rtl/core/ilbm_queue.sv =====
module ilbm_queue
  import ilbm_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output job_t head,
  output logic empty,
  output logic full
);

  localparam int unsigned PW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  job_t          slots [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign empty = (count == '0);
  assign full = (count == CW'(QUEUE_DEPTH));
  assign head = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full || pop)
    else $error("job pushed into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("job popped from empty queue");
`endif

endmodule

// ===== rtl/core/ilbm_back.sv =====
module ilbm_back
  import ilbm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  job_t        head,
  input  logic        empty,
  output logic        pop,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,
  output logic [1:0]  m_axis_tuser,
  output logic        m_axis_tlast
);

  logic [3:0]  idx;
  logic [3:0]  n_main;
  logic [3:0]  total;
  logic        is_main;
  logic        is_last;
  logic        out_free;
  logic        load;
  res_kind_t   kind_out;
  logic [XW-1:0] x_full;

  res_kind_t   r_kind;
  logic [8:0]  r_x;
  logic [7:0]  r_y;
  logic [7:0]  r_value;
  logic [8:0]  r_width;
  logic [8:0]  r_height;
  logic [7:0]  r_planes;
  logic        r_status;
  logic        r_last;

  assign n_main = (head.kind == RK_PIXEL) ? head.npix : 4'd1;
  assign total = n_main + {3'b000, head.fin};
  assign is_main = (idx < n_main);
  assign is_last = ((idx + 4'd1) == total);
  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign load = out_free && !empty;
  assign pop = load && is_last;
  assign kind_out = is_main ? head.kind : RK_FINISH;
  assign x_full = head.base_x + XW'(idx);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
      idx           <= '0;
    end else begin
      if (load) begin
        m_axis_tvalid <= 1'b1;
        idx           <= is_last ? 4'd0 : idx + 4'd1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      r_kind   <= kind_out;
      r_last   <= is_last;
      r_x      <= '0;
      r_y      <= '0;
      r_value  <= '0;
      r_width  <= '0;
      r_height <= '0;
      r_planes <= '0;
      r_status <= ST_OK;
      case (kind_out)
        RK_INFO: begin
          r_width  <= head.width[8:0];
          r_height <= head.height[8:0];
          r_planes <= head.planes;
        end
        RK_PIXEL: begin
          r_x     <= x_full[8:0];
          r_y     <= head.row[7:0];
          r_value <= head.data[3'd7 - idx[2:0]] ? PIXEL_ON : PIXEL_OFF;
        end
        RK_FINISH: r_status <= head.status;
        default: ;
      endcase
    end
  end

  // tdata: pixel_x, pixel_y, pixel_value, image_width, image_height, plane_count, load_status
  assign m_axis_tdata = {4'b0000, r_status, r_planes, r_height, r_width, r_value, r_y, r_x};
  assign m_axis_tuser = r_kind;
  assign m_axis_tlast = r_last;

`ifndef SYNTHESIS
  a_finish_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser == RK_FINISH |-> m_axis_tlast)
    else $error("finish transaction not marked last");
  a_pixel_value: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser == RK_PIXEL |->
      m_axis_tdata[24:17] == PIXEL_ON || m_axis_tdata[24:17] == PIXEL_OFF)
    else $error("pixel value neither on nor off");
  a_idx_bound: assert property (@(posedge clk) disable iff (rst)
    !empty |-> idx < total)
    else $error("result index beyond job length");
`endif

endmodule

// ===== rtl/core/iff_ilbm_bitplane_parser_core.sv =====
// Parses an IFF ILBM file streamed in one byte per transaction (tuser high marks the end of
// the file) and returns image info, first-plane pixels (0 or 255) and a finish status. The
// chunk parser takes input bytes while the job queue is not full; a BODY byte yields one
// result per pixel it covers (up to eight), plus a finish result if it ends the image, and
// the result unit emits one result per cycle unless m_axis_tready stalls it. A four-entry
// job queue between them lets input be taken while earlier bytes are still being unpacked.
module iff_ilbm_bitplane_parser_core
  import ilbm_pkg::*;
#(
  parameter int unsigned MAX_WIDTH = 320,
  parameter int unsigned MAX_HEIGHT = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // data_byte
  input  logic [0:0]  s_axis_tuser,  // end_marker
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,  // pixel_x, pixel_y, pixel_value, image_width,
                                     // image_height, plane_count, load_status, zero fill
  output logic [1:0]  m_axis_tuser,  // result_kind
  output logic        m_axis_tlast   // run_last
);

  logic job_push;
  job_t push_job;
  job_t head;
  logic empty;
  logic full;
  logic pop;

  ilbm_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .data_byte (s_axis_tdata),
    .end_marker(s_axis_tuser[0]),
    .job_push  (job_push),
    .job       (push_job),
    .queue_full(full)
  );

  ilbm_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (job_push),
    .push_job(push_job),
    .pop     (pop),
    .head    (head),
    .empty   (empty),
    .full    (full)
  );

  ilbm_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .empty        (empty),
    .pop          (pop),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

endmodule
